### rtl/look_rotation_quaternion_macros.svh
// Assertion macros for the look-rotation quaternion block.
// Used by the top level; expects signals clk and rst in scope.
`ifndef LOOK_ROTATION_QUATERNION_MACROS_SVH
`define LOOK_ROTATION_QUATERNION_MACROS_SVH

// same-cycle implication, disabled in reset
`define LRQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define LRQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/lrq_pkg.sv
// Shared types and constants for the look-rotation quaternion block.
// No dependencies.
`default_nettype none
package lrq_pkg;
  localparam int FIX_W = 32;   // Q2.30 unit components and Q3.29 outputs
  localparam int MAG_W = 31;   // prescaled magnitude width

  typedef enum logic [1:0] {
    BR_X = 2'd0,
    BR_Y = 2'd1,
    BR_Z = 2'd2,
    BR_W = 2'd3
  } branch_t;
endpackage
`default_nettype wire

### rtl/look_rotation_quaternion.sv
// Look-rotation quaternion, fully pipelined: throughput one item per cycle
// while the output register is not stalled.
// The pipeline holds two normalizers (each: 32-stage root, 32-stage divide),
// the 32-stage trace root and the 32-stage quaternion divide.
// The whole pipeline advances when the output register is empty or taken.
// Synchronous reset clears all valid bits; data registers are not reset.
`default_nettype none
`include "look_rotation_quaternion_macros.svh"
module look_rotation_quaternion import lrq_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // look_x, look_y, look_z, up_x, up_y, up_z (32 bits each, from bit 0)
  input  logic [191:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // quat_x, quat_y, quat_z, quat_w (32 bits each, from bit 0)
  output logic [127:0] m_tdata,
  // degenerate
  output logic [0:0]   m_tuser
);
  localparam logic [127:0] IDENT_DATA = {32'h2000_0000, 96'd0};
  localparam int D_W = 33;

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // forward = normalize(look)
  logic                  v_n1;
  logic [2:0][FIX_W-1:0] f_n1;
  logic                  zero_n1;
  logic [95:0]           up_n1;

  lrq_norm #(.IN_W(32), .SIDE_W(96)) u_norm_look (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s_tvalid), .in_vec(s_tdata[95:0]), .in_side(s_tdata[191:96]),
    .out_valid(v_n1), .out_unit(f_n1), .out_zero(zero_n1), .out_side(up_n1)
  );

  // cross(up, forward): products
  logic                  v_c1;
  logic signed [63:0]    pc [6];
  logic [2:0][FIX_W-1:0] f_c1;
  logic                  deg_c1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_c1 <= 1'b0;
    end else if (en) begin
      v_c1 <= v_n1;
    end
    if (en) begin
      pc[0]  <= $signed(up_n1[63:32]) * $signed(f_n1[2]);
      pc[1]  <= $signed(up_n1[95:64]) * $signed(f_n1[1]);
      pc[2]  <= $signed(up_n1[95:64]) * $signed(f_n1[0]);
      pc[3]  <= $signed(up_n1[31:0])  * $signed(f_n1[2]);
      pc[4]  <= $signed(up_n1[31:0])  * $signed(f_n1[1]);
      pc[5]  <= $signed(up_n1[63:32]) * $signed(f_n1[0]);
      f_c1   <= f_n1;
      deg_c1 <= zero_n1;
    end
  end

  logic                  v_c2;
  logic [2:0][63:0]      c_c2;
  logic [2:0][FIX_W-1:0] f_c2;
  logic                  deg_c2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_c2 <= 1'b0;
    end else if (en) begin
      v_c2 <= v_c1;
    end
    if (en) begin
      c_c2[0] <= pc[0] - pc[1];
      c_c2[1] <= pc[2] - pc[3];
      c_c2[2] <= pc[4] - pc[5];
      f_c2    <= f_c1;
      deg_c2  <= deg_c1;
    end
  end

  // right = normalize(cross)
  logic                  v_n2;
  logic [2:0][FIX_W-1:0] r_n2;
  logic                  zero_n2;
  logic [2:0][FIX_W-1:0] f_n2;
  logic                  deg_n2;

  lrq_norm #(.IN_W(64), .SIDE_W(97)) u_norm_right (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v_c2), .in_vec(c_c2), .in_side({f_c2, deg_c2}),
    .out_valid(v_n2), .out_unit(r_n2), .out_zero(zero_n2),
    .out_side({f_n2, deg_n2})
  );

  // up = cross(forward, right): products
  logic                  v_t1;
  logic signed [63:0]    pt [6];
  logic [2:0][FIX_W-1:0] r_t1;
  logic [2:0][FIX_W-1:0] f_t1;
  logic                  deg_t1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_t1 <= 1'b0;
    end else if (en) begin
      v_t1 <= v_n2;
    end
    if (en) begin
      pt[0]  <= $signed(f_n2[1]) * $signed(r_n2[2]);
      pt[1]  <= $signed(f_n2[2]) * $signed(r_n2[1]);
      pt[2]  <= $signed(f_n2[2]) * $signed(r_n2[0]);
      pt[3]  <= $signed(f_n2[0]) * $signed(r_n2[2]);
      pt[4]  <= $signed(f_n2[0]) * $signed(r_n2[1]);
      pt[5]  <= $signed(f_n2[1]) * $signed(r_n2[0]);
      r_t1   <= r_n2;
      f_t1   <= f_n2;
      deg_t1 <= deg_n2 | zero_n2;
    end
  end

  // round Q4.60 to Q2.30
  logic signed [63:0] tsum [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tsum[i] = (pt[2*i] - pt[2*i+1] + 64'sd536870912) >>> 30;
    end
  end

  logic                     v_t2;
  logic signed [FIX_W-1:0]  m_r [3];
  logic signed [FIX_W-1:0]  m_t [3];
  logic signed [FIX_W-1:0]  m_f [3];
  logic                     deg_t2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_t2 <= 1'b0;
    end else if (en) begin
      v_t2 <= v_t1;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m_r[i] <= $signed(r_t1[i]);
        m_t[i] <= tsum[i][FIX_W-1:0];
        m_f[i] <= $signed(f_t1[i]);
      end
      deg_t2 <= deg_t1;
    end
  end

  // trace and branch choice
  logic signed [33:0] tr;
  branch_t            which_c;

  assign tr = 34'(m_r[0]) + 34'(m_t[1]) + 34'(m_f[2]);

  always_comb begin
    if (tr > 0) begin
      which_c = BR_W;
    end else if (m_r[0] >= m_t[1] && m_r[0] >= m_f[2]) begin
      which_c = BR_X;
    end else if (m_t[1] > m_f[2]) begin
      which_c = BR_Y;
    end else begin
      which_c = BR_Z;
    end
  end

  logic                    v_b1;
  logic signed [33:0]      tr_b1;
  branch_t                 which_b1;
  logic signed [FIX_W-1:0] b_r [3];
  logic signed [FIX_W-1:0] b_t [3];
  logic signed [FIX_W-1:0] b_f [3];
  logic                    deg_b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_b1 <= 1'b0;
    end else if (en) begin
      v_b1 <= v_t2;
    end
    if (en) begin
      tr_b1    <= tr;
      which_b1 <= which_c;
      b_r      <= m_r;
      b_t      <= m_t;
      b_f      <= m_f;
      deg_b1   <= deg_t2;
    end
  end

  // branch argument and off-diagonal sums
  logic signed [35:0]    arg_c;
  logic signed [D_W-1:0] d_c [3];
  localparam logic signed [35:0] ONE_Q30 = 36'sd1073741824;

  always_comb begin
    case (which_b1)
      BR_W: begin
        arg_c  = 36'(tr_b1) + ONE_Q30;
        d_c[0] = D_W'(b_t[2]) - D_W'(b_f[1]);
        d_c[1] = D_W'(b_f[0]) - D_W'(b_r[2]);
        d_c[2] = D_W'(b_r[1]) - D_W'(b_t[0]);
      end
      BR_X: begin
        arg_c  = ONE_Q30 + 36'(b_r[0]) - 36'(b_t[1]) - 36'(b_f[2]);
        d_c[0] = D_W'(b_r[1]) + D_W'(b_t[0]);
        d_c[1] = D_W'(b_r[2]) + D_W'(b_f[0]);
        d_c[2] = D_W'(b_t[2]) - D_W'(b_f[1]);
      end
      BR_Y: begin
        arg_c  = ONE_Q30 + 36'(b_t[1]) - 36'(b_r[0]) - 36'(b_f[2]);
        d_c[0] = D_W'(b_t[0]) + D_W'(b_r[1]);
        d_c[1] = D_W'(b_f[1]) + D_W'(b_t[2]);
        d_c[2] = D_W'(b_f[0]) - D_W'(b_r[2]);
      end
      default: begin
        arg_c  = ONE_Q30 + 36'(b_f[2]) - 36'(b_r[0]) - 36'(b_t[1]);
        d_c[0] = D_W'(b_f[0]) + D_W'(b_r[2]);
        d_c[1] = D_W'(b_f[1]) + D_W'(b_t[2]);
        d_c[2] = D_W'(b_r[1]) - D_W'(b_t[0]);
      end
    endcase
  end

  logic                  v_b2;
  logic [33:0]           arg_b2;
  logic [1:0]            which_b2;
  logic [2:0][D_W-1:0]   d_b2;
  logic                  deg_b2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_b2 <= 1'b0;
    end else if (en) begin
      v_b2 <= v_b1;
    end
    if (en) begin
      arg_b2   <= arg_c[35] ? 34'd0 : arg_c[33:0];
      which_b2 <= which_b1;
      for (int i = 0; i < 3; i++) begin
        d_b2[i] <= d_c[i];
      end
      deg_b2 <= deg_b1;
    end
  end

  // S = sqrt(arg) in Q2.30
  logic                v_s;
  logic [31:0]         s_root;
  logic [1:0]          which_s;
  logic [2:0][D_W-1:0] d_s;
  logic                deg_s;

  lrq_isqrt #(.IN_W(64), .SIDE_W(2 + 3 * D_W + 1)) u_isqrt_tr (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v_b2), .in_n({arg_b2, 30'd0}),
    .in_side({which_b2, d_b2, deg_b2}),
    .out_valid(v_s), .out_root(s_root), .out_side({which_s, d_s, deg_s})
  );

  // diagonal term and divider numerators
  logic [31:0]         s_fix;
  logic [32:0]         diag_c;
  logic [2:0][D_W-1:0] d_abs;

  assign s_fix  = (s_root == '0) ? 32'd1 : s_root;
  assign diag_c = 33'(s_fix) + 33'd2;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_abs[i] = d_s[i][D_W-1] ? (~d_s[i] + 1'b1) : d_s[i];
    end
  end

  logic                v_q1;
  logic [31:0]         s_q1;
  logic [30:0]         diag_q1;
  logic [2:0][61:0]    num_q1;
  logic [2:0]          neg_q1;
  logic [1:0]          which_q1;
  logic                deg_q1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q1 <= 1'b0;
    end else if (en) begin
      v_q1 <= v_s;
    end
    if (en) begin
      s_q1    <= s_fix;
      diag_q1 <= diag_c[32:2];
      for (int i = 0; i < 3; i++) begin
        num_q1[i] <= {1'b0, d_abs[i], 28'd0} + {31'd0, s_fix[31:1]};
        neg_q1[i] <= d_s[i][D_W-1];
      end
      which_q1 <= which_s;
      deg_q1   <= deg_s;
    end
  end

  // d * 2^28 / S
  logic [2:0][31:0] quo;
  logic [2:0]       ovf;
  logic [2:0]       neg_dv;
  logic             v_dv;
  logic             v_dv1;
  logic             v_dv2;
  logic [1:0]       which_dv;
  logic [30:0]      diag_dv;
  logic             deg_dv;

  lrq_div #(.NUM_W(62), .DEN_W(32), .Q_W(32), .SIDE_W(35)) u_div_q0 (
    .clk(clk), .rst(rst), .en(en), .in_valid(v_q1),
    .in_num(num_q1[0]), .in_den(s_q1),
    .in_side({neg_q1[0], which_q1, diag_q1, deg_q1}),
    .out_valid(v_dv), .out_quot(quo[0]), .out_ovf(ovf[0]),
    .out_side({neg_dv[0], which_dv, diag_dv, deg_dv})
  );

  lrq_div #(.NUM_W(62), .DEN_W(32), .Q_W(32), .SIDE_W(1)) u_div_q1 (
    .clk(clk), .rst(rst), .en(en), .in_valid(v_q1),
    .in_num(num_q1[1]), .in_den(s_q1), .in_side(neg_q1[1]),
    .out_valid(v_dv1), .out_quot(quo[1]), .out_ovf(ovf[1]), .out_side(neg_dv[1])
  );

  lrq_div #(.NUM_W(62), .DEN_W(32), .Q_W(32), .SIDE_W(1)) u_div_q2 (
    .clk(clk), .rst(rst), .en(en), .in_valid(v_q1),
    .in_num(num_q1[2]), .in_den(s_q1), .in_side(neg_q1[2]),
    .out_valid(v_dv2), .out_quot(quo[2]), .out_ovf(ovf[2]), .out_side(neg_dv[2])
  );

  function automatic logic [31:0] sat_q(input logic neg, input logic of,
                                        input logic [31:0] q);
    logic [31:0] res;
    if (!neg) begin
      res = (of || q[31]) ? 32'h7FFF_FFFF : q;
    end else begin
      res = (of || q > 32'h8000_0000) ? 32'h8000_0000 : (~q + 1'b1);
    end
    return res;
  endfunction

  logic [2:0][31:0] dq;
  logic [31:0]      diag_w;
  logic [127:0]     quat_c;

  assign diag_w = {1'b0, diag_dv};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dq[i] = sat_q(neg_dv[i], ovf[i], quo[i]);
    end
    case (branch_t'(which_dv))
      BR_X:    quat_c = {dq[2], dq[1], dq[0], diag_w};
      BR_Y:    quat_c = {dq[2], dq[1], diag_w, dq[0]};
      BR_Z:    quat_c = {dq[2], diag_w, dq[1], dq[0]};
      default: quat_c = {diag_w, dq[2], dq[1], dq[0]};
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= v_dv & v_dv1 & v_dv2;
    end
    if (en) begin
      m_tdata    <= deg_dv ? IDENT_DATA : quat_c;
      m_tuser[0] <= deg_dv;
    end
  end

  `LRQ_ASSERT_IMP(a_degenerate_identity, m_tvalid && m_tuser[0], m_tdata == IDENT_DATA, "degenerate item without identity quaternion")
  `LRQ_ASSERT_IMP(a_quat_nonzero, m_tvalid && !m_tuser[0], m_tdata != '0, "all-zero quaternion on regular item")
endmodule
`default_nettype wire

### rtl/lrq_isqrt.sv
// Pipelined integer square root, one result bit per stage.
// Uses no package; sideband bits travel alongside.
`default_nettype none
module lrq_isqrt #(
  parameter int IN_W   = 64,
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [IN_W-1:0]     in_n,
  input  logic [SIDE_W-1:0]   in_side,
  output logic                out_valid,
  output logic [IN_W/2-1:0]   out_root,
  output logic [SIDE_W-1:0]   out_side
);
  localparam int N = IN_W / 2;

  logic              v_a    [1:N];
  logic [IN_W-1:0]   n_a    [1:N];
  logic [IN_W-1:0]   r_a    [1:N];
  logic [SIDE_W-1:0] side_a [1:N];

  for (genvar k = 0; k < N; k++) begin : g_st
    localparam logic [IN_W-1:0] BITV = IN_W'(1) << (IN_W - 2 - 2 * k);
    logic              v_i;
    logic [IN_W-1:0]   n_i;
    logic [IN_W-1:0]   r_i;
    logic [SIDE_W-1:0] s_i;
    logic [IN_W-1:0]   trial;

    if (k == 0) begin : g_first
      assign v_i = in_valid;
      assign n_i = in_n;
      assign r_i = '0;
      assign s_i = in_side;
    end else begin : g_rest
      assign v_i = v_a[k];
      assign n_i = n_a[k];
      assign r_i = r_a[k];
      assign s_i = side_a[k];
    end

    assign trial = r_i + BITV;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_a[k+1] <= 1'b0;
      end else if (en) begin
        v_a[k+1] <= v_i;
      end
      if (en) begin
        side_a[k+1] <= s_i;
        if (n_i >= trial) begin
          n_a[k+1] <= n_i - trial;
          r_a[k+1] <= (r_i >> 1) + BITV;
        end else begin
          n_a[k+1] <= n_i;
          r_a[k+1] <= r_i >> 1;
        end
      end
    end
  end

  assign out_valid = v_a[N];
  assign out_root  = r_a[N][N-1:0];
  assign out_side  = side_a[N];
endmodule
`default_nettype wire

### rtl/lrq_div.sv
// Pipelined restoring divider, one quotient bit per stage, with an
// overflow flag when the quotient does not fit. Uses no package.
`default_nettype none
module lrq_div #(
  parameter int NUM_W  = 62,
  parameter int DEN_W  = 32,
  parameter int Q_W    = 32,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [Q_W-1:0]    out_quot,
  output logic              out_ovf,
  output logic [SIDE_W-1:0] out_side
);
  localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic              v_a    [1:Q_W];
  logic [CW-1:0]     rem_a  [1:Q_W];
  logic [DEN_W-1:0]  den_a  [1:Q_W];
  logic [Q_W-1:0]    quo_a  [1:Q_W];
  logic              ovf_a  [1:Q_W];
  logic [SIDE_W-1:0] side_a [1:Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_st
    localparam int B = Q_W - 1 - k;
    logic              v_i;
    logic [CW-1:0]     rem_i;
    logic [DEN_W-1:0]  den_i;
    logic [Q_W-1:0]    quo_i;
    logic              ovf_i;
    logic [SIDE_W-1:0] s_i;
    logic [CW-1:0]     dsh;
    logic              take;

    if (k == 0) begin : g_first
      assign v_i   = in_valid;
      assign rem_i = CW'(in_num);
      assign den_i = in_den;
      assign quo_i = '0;
      // quotient overflows when num >= den * 2^Q_W
      assign ovf_i = (CW'(in_num) >> Q_W) >= CW'(in_den);
      assign s_i   = in_side;
    end else begin : g_rest
      assign v_i   = v_a[k];
      assign rem_i = rem_a[k];
      assign den_i = den_a[k];
      assign quo_i = quo_a[k];
      assign ovf_i = ovf_a[k];
      assign s_i   = side_a[k];
    end

    assign dsh  = CW'(den_i) << B;
    assign take = rem_i >= dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_a[k+1] <= 1'b0;
      end else if (en) begin
        v_a[k+1] <= v_i;
      end
      if (en) begin
        rem_a[k+1]  <= take ? rem_i - dsh : rem_i;
        den_a[k+1]  <= den_i;
        quo_a[k+1]  <= quo_i | (take ? (Q_W'(1) << B) : Q_W'(0));
        ovf_a[k+1]  <= ovf_i;
        side_a[k+1] <= s_i;
      end
    end
  end

  assign out_valid = v_a[Q_W];
  assign out_quot  = quo_a[Q_W];
  assign out_ovf   = ovf_a[Q_W];
  assign out_side  = side_a[Q_W];
endmodule
`default_nettype wire

### rtl/lrq_norm.sv
// Pipelined 3-vector normalizer: prescale, sum of squares, square root
// and three dividers giving Q2.30 unit components. Uses lrq_pkg,
// lrq_isqrt and lrq_div.
`default_nettype none
module lrq_norm import lrq_pkg::*; #(
  parameter int IN_W   = 32,
  parameter int SIDE_W = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [2:0][IN_W-1:0]  in_vec,
  input  logic [SIDE_W-1:0]     in_side,
  output logic                  out_valid,
  output logic [2:0][FIX_W-1:0] out_unit,
  output logic                  out_zero,
  output logic [SIDE_W-1:0]     out_side
);
  localparam int NSH   = 11;               // 6 right steps, 5 left steps
  localparam int SQ_W  = 2 * MAG_W;
  localparam int NUM_W = MAG_W + 31;
  localparam int ISW   = 3 * MAG_W + 4 + SIDE_W;

  // magnitude and sign
  logic                 v1;
  logic [2:0][IN_W-1:0] mag1;
  logic [2:0]           neg1;
  logic [SIDE_W-1:0]    side1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg1[i] <= in_vec[i][IN_W-1];
        mag1[i] <= in_vec[i][IN_W-1] ? (~in_vec[i] + 1'b1) : in_vec[i];
      end
      side1 <= in_side;
    end
  end

  // max magnitude, then shift steps
  logic                 sh_v    [0:NSH];
  logic [IN_W-1:0]      sh_mx   [0:NSH];
  logic [2:0][IN_W-1:0] sh_mag  [0:NSH];
  logic [2:0]           sh_neg  [0:NSH];
  logic                 sh_zero [0:NSH];
  logic [SIDE_W-1:0]    sh_side [0:NSH];
  logic [IN_W-1:0]      m01;
  logic [IN_W-1:0]      mx1;

  assign m01 = (mag1[0] >= mag1[1]) ? mag1[0] : mag1[1];
  assign mx1 = (m01 >= mag1[2]) ? m01 : mag1[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      sh_v[0] <= 1'b0;
    end else if (en) begin
      sh_v[0] <= v1;
    end
    if (en) begin
      sh_mx[0]   <= mx1;
      sh_mag[0]  <= mag1;
      sh_neg[0]  <= neg1;
      sh_zero[0] <= ~|mag1;
      sh_side[0] <= side1;
    end
  end

  for (genvar j = 0; j < NSH; j++) begin : g_sh
    localparam bit RIGHT = (j < 6);
    localparam int AMT   = (j < 6) ? (32 >> j) : (16 >> (j - 6));
    logic doit;

    // right: bring max below 2^31; left: bring max up to 2^30
    assign doit = RIGHT ? ((sh_mx[j] >> (30 + AMT)) != '0)
                        : ((sh_mx[j] >> (31 - AMT)) == '0);

    always_ff @(posedge clk) begin
      if (rst) begin
        sh_v[j+1] <= 1'b0;
      end else if (en) begin
        sh_v[j+1] <= sh_v[j];
      end
      if (en) begin
        sh_neg[j+1]  <= sh_neg[j];
        sh_zero[j+1] <= sh_zero[j];
        sh_side[j+1] <= sh_side[j];
        if (doit) begin
          sh_mx[j+1] <= RIGHT ? (sh_mx[j] >> AMT) : (sh_mx[j] << AMT);
          for (int i = 0; i < 3; i++) begin
            sh_mag[j+1][i] <= RIGHT ? (sh_mag[j][i] >> AMT) : (sh_mag[j][i] << AMT);
          end
        end else begin
          sh_mx[j+1]  <= sh_mx[j];
          sh_mag[j+1] <= sh_mag[j];
        end
      end
    end
  end

  // squares
  logic                  v_sq;
  logic [2:0][MAG_W-1:0] mag_sq;
  logic [SQ_W-1:0]       sq     [3];
  logic [2:0]            neg_sq;
  logic                  zero_sq;
  logic [SIDE_W-1:0]     side_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_sq <= 1'b0;
    end else if (en) begin
      v_sq <= sh_v[NSH];
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag_sq[i] <= sh_mag[NSH][i][MAG_W-1:0];
        sq[i]     <= sh_mag[NSH][i][MAG_W-1:0] * sh_mag[NSH][i][MAG_W-1:0];
      end
      neg_sq  <= sh_neg[NSH];
      zero_sq <= sh_zero[NSH];
      side_sq <= sh_side[NSH];
    end
  end

  // sum of squares
  logic                  v_sum;
  logic [63:0]           sum;
  logic [2:0][MAG_W-1:0] mag_sum;
  logic [2:0]            neg_sum;
  logic                  zero_sum;
  logic [SIDE_W-1:0]     side_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_sum <= 1'b0;
    end else if (en) begin
      v_sum <= v_sq;
    end
    if (en) begin
      sum      <= 64'(sq[0]) + 64'(sq[1]) + 64'(sq[2]);
      mag_sum  <= mag_sq;
      neg_sum  <= neg_sq;
      zero_sum <= zero_sq;
      side_sum <= side_sq;
    end
  end

  // length
  logic                  v_len;
  logic [31:0]           len;
  logic [ISW-1:0]        isq_side;
  logic [2:0][MAG_W-1:0] mag_len;
  logic [2:0]            neg_len;
  logic                  zero_len;
  logic [SIDE_W-1:0]     side_len;

  lrq_isqrt #(.IN_W(64), .SIDE_W(ISW)) u_isqrt (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v_sum), .in_n(sum),
    .in_side({side_sum, zero_sum, neg_sum, mag_sum}),
    .out_valid(v_len), .out_root(len), .out_side(isq_side)
  );

  assign {side_len, zero_len, neg_len, mag_len} = isq_side;

  // round(mag * 2^30 / len)
  logic [2:0][FIX_W-1:0] quo;
  logic [2:0]            ovf_unused;
  logic                  v_dv;
  logic [2:0]            neg_dv;
  logic                  zero_dv;
  logic [SIDE_W-1:0]     side_dv;
  logic                  v_dv1;
  logic                  v_dv2;

  lrq_div #(.NUM_W(NUM_W), .DEN_W(32), .Q_W(FIX_W), .SIDE_W(SIDE_W + 2)) u_div0 (
    .clk(clk), .rst(rst), .en(en), .in_valid(v_len),
    .in_num({1'b0, mag_len[0], 30'd0} + {31'd0, len[31:1]}),
    .in_den(len), .in_side({side_len, zero_len, neg_len[0]}),
    .out_valid(v_dv), .out_quot(quo[0]), .out_ovf(ovf_unused[0]),
    .out_side({side_dv, zero_dv, neg_dv[0]})
  );

  lrq_div #(.NUM_W(NUM_W), .DEN_W(32), .Q_W(FIX_W), .SIDE_W(1)) u_div1 (
    .clk(clk), .rst(rst), .en(en), .in_valid(v_len),
    .in_num({1'b0, mag_len[1], 30'd0} + {31'd0, len[31:1]}),
    .in_den(len), .in_side(neg_len[1]),
    .out_valid(v_dv1), .out_quot(quo[1]), .out_ovf(ovf_unused[1]),
    .out_side(neg_dv[1])
  );

  lrq_div #(.NUM_W(NUM_W), .DEN_W(32), .Q_W(FIX_W), .SIDE_W(1)) u_div2 (
    .clk(clk), .rst(rst), .en(en), .in_valid(v_len),
    .in_num({1'b0, mag_len[2], 30'd0} + {31'd0, len[31:1]}),
    .in_den(len), .in_side(neg_len[2]),
    .out_valid(v_dv2), .out_quot(quo[2]), .out_ovf(ovf_unused[2]),
    .out_side(neg_dv[2])
  );

  // sign restore; dividers run in lockstep and their valids are ANDed
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_dv & v_dv1 & v_dv2;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        out_unit[i] <= neg_dv[i] ? (~quo[i] + 1'b1) : quo[i];
      end
      out_zero <= zero_dv;
      out_side <= side_dv;
    end
  end
endmodule
`default_nettype wire
